/* src/akeys_pkg.sv */
// shared types, key codes and helpers for the alarm clock remote key unit
// no dependencies

package akeys_pkg;

  localparam int CodeWidth = 32;
  localparam int DigitWidth = 4;
  localparam int NumDigits = 4;

  localparam logic [CodeWidth-1:0] KEY_POWER = 32'hED127F80;
  localparam logic [CodeWidth-1:0] KEY_MODE  = 32'hE51A7F80;
  localparam logic [CodeWidth-1:0] KEY_MUTE  = 32'hE11E7F80;
  localparam logic [CodeWidth-1:0] KEY_D0    = 32'hF8077F80;
  localparam logic [CodeWidth-1:0] KEY_D1    = 32'hF50A7F80;
  localparam logic [CodeWidth-1:0] KEY_D2    = 32'hE41B7F80;
  localparam logic [CodeWidth-1:0] KEY_D3    = 32'hE01F7F80;
  localparam logic [CodeWidth-1:0] KEY_D4    = 32'hF30C7F80;
  localparam logic [CodeWidth-1:0] KEY_D5    = 32'hF20D7F80;
  localparam logic [CodeWidth-1:0] KEY_D6    = 32'hF10E7F80;
  localparam logic [CodeWidth-1:0] KEY_D7    = 32'hFF007F80;
  localparam logic [CodeWidth-1:0] KEY_D8    = 32'hF00F7F80;
  localparam logic [CodeWidth-1:0] KEY_D9    = 32'hE6197F80;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_REMOTE = 1'b1;

  localparam logic [6:0] MAX_HOUR   = 7'd23;
  localparam logic [6:0] MAX_MINUTE = 7'd59;
  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [4:0] LAST_HOUR   = 5'd23;

  typedef logic [DigitWidth-1:0] digit_t;

  // decoded remote key
  typedef struct packed {
    logic   power;
    logic   mode;
    logic   mute;
    logic   is_digit;
    digit_t digit;
  } key_t;

  // two decimal digits to binary, clamped to a limit
  function automatic logic [6:0] pair_to_bin(input digit_t tens, input digit_t ones,
                                             input logic [6:0] limit);
    logic [6:0] sum;
    sum = {tens, 3'b000} + {2'b00, tens, 1'b0} + {3'b000, ones};
    pair_to_bin = (sum > limit) ? limit : sum;
  endfunction

endpackage

/* src/akeys_if.sv */
// valid/ready channel interfaces for the remote key unit
// no dependencies

interface akeys_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] remote_code;

  modport source(output valid, output cmd, output remote_code, input ready);
  modport sink(input valid, input cmd, input remote_code, output ready);
endinterface

interface akeys_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic        display_on;
  logic        alarm_sounding;
  logic        alarm_is_armed;
  logic        entering;
  logic        entering_alarm;
  logic [1:0]  digits_entered;
  logic [15:0] entry_value;

  modport source(output valid, output hours, output minutes, output seconds,
                 output display_on, output alarm_sounding, output alarm_is_armed,
                 output entering, output entering_alarm, output digits_entered,
                 output entry_value, input ready);
  modport sink(input valid, input hours, input minutes, input seconds,
               input display_on, input alarm_sounding, input alarm_is_armed,
               input entering, input entering_alarm, input digits_entered,
               input entry_value, output ready);
endinterface

/* src/akeys_decode.sv */
// remote code decoder: raw infrared code to key struct
// depends on akeys_pkg

module akeys_decode
  import akeys_pkg::*;
(
  input  logic [CodeWidth-1:0] code,
  output key_t                 key
);

  always_comb begin
    key = '0;
    unique case (code)
      KEY_POWER: key.power = 1'b1;
      KEY_MODE:  key.mode = 1'b1;
      KEY_MUTE:  key.mute = 1'b1;
      KEY_D0: begin key.is_digit = 1'b1; key.digit = 4'd0; end
      KEY_D1: begin key.is_digit = 1'b1; key.digit = 4'd1; end
      KEY_D2: begin key.is_digit = 1'b1; key.digit = 4'd2; end
      KEY_D3: begin key.is_digit = 1'b1; key.digit = 4'd3; end
      KEY_D4: begin key.is_digit = 1'b1; key.digit = 4'd4; end
      KEY_D5: begin key.is_digit = 1'b1; key.digit = 4'd5; end
      KEY_D6: begin key.is_digit = 1'b1; key.digit = 4'd6; end
      KEY_D7: begin key.is_digit = 1'b1; key.digit = 4'd7; end
      KEY_D8: begin key.is_digit = 1'b1; key.digit = 4'd8; end
      KEY_D9: begin key.is_digit = 1'b1; key.digit = 4'd9; end
      default: key = '0;
    endcase
  end

endmodule

/* src/alarm_clock_remote_keys_unit.sv */
// top level of the alarm clock remote key unit
// depends on akeys_pkg, akeys_if and akeys_decode
//
//   channel  dir  payload                                           modport
//   keys     in   cmd, remote_code                                  sink
//   status   out  hours .. entry_value (state after the transfer)   source
//
// one item per cycle while the status channel does not stall; each input transfer yields
// one status word on the next cycle, set by a single register stage behind the key decoder
// rst (synchronous) clears the clock, alarm and entry state and the output
// valid; the display comes up enabled
// while a status word waits, keys.ready follows status.ready

module alarm_clock_remote_keys_unit
  import akeys_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  akeys_in_if.sink     keys,
  akeys_out_if.source  status
);

  logic [4:0] hour_count, hour_count_next;
  logic [5:0] minute_count, minute_count_next;
  logic [5:0] second_count, second_count_next;
  logic [4:0] alarm_hour, alarm_hour_next;
  logic [5:0] alarm_minute, alarm_minute_next;
  logic       armed_flag, armed_flag_next;
  logic       display_enable, display_enable_next;
  logic       next_target_alarm, next_target_alarm_next;
  logic       entry_busy, entry_busy_next;
  logic       entry_target, entry_target_next;
  logic [1:0] entry_count, entry_count_next;
  digit_t     entry_digit [NumDigits];
  digit_t     entry_digit_next [NumDigits];

  key_t       key;
  logic       accept;
  logic [6:0] set_hour;
  logic [6:0] set_minute;

  akeys_decode u_decode (
    .code (keys.remote_code),
    .key  (key)
  );

  assign keys.ready = !status.valid || status.ready;
  assign accept     = keys.valid && keys.ready;

  // the fourth digit is the incoming one
  assign set_hour   = pair_to_bin(entry_digit[0], entry_digit[1], MAX_HOUR);
  assign set_minute = pair_to_bin(entry_digit[2], key.digit, MAX_MINUTE);

  always_comb begin
    hour_count_next        = hour_count;
    minute_count_next      = minute_count;
    second_count_next      = second_count;
    alarm_hour_next        = alarm_hour;
    alarm_minute_next      = alarm_minute;
    armed_flag_next        = armed_flag;
    display_enable_next    = display_enable;
    next_target_alarm_next = next_target_alarm;
    entry_busy_next        = entry_busy;
    entry_target_next      = entry_target;
    entry_count_next       = entry_count;
    for (int i = 0; i < NumDigits; i++) begin
      entry_digit_next[i] = entry_digit[i];
    end

    if (keys.cmd == CMD_TICK) begin
      if (!entry_busy) begin
        if (second_count == LAST_SECOND) begin
          second_count_next = '0;
          if (minute_count == LAST_MINUTE) begin
            minute_count_next = '0;
            hour_count_next   = (hour_count == LAST_HOUR) ? 5'd0 : hour_count + 5'd1;
          end else begin
            minute_count_next = minute_count + 6'd1;
          end
        end else begin
          second_count_next = second_count + 6'd1;
        end
      end
    end else if (!entry_busy) begin
      if (key.power) begin
        display_enable_next = !display_enable;
      end else if (key.mute) begin
        armed_flag_next = 1'b0;
      end else if (key.mode) begin
        entry_busy_next   = 1'b1;
        entry_target_next = next_target_alarm;
        entry_count_next  = '0;
        for (int i = 0; i < NumDigits; i++) entry_digit_next[i] = '0;
      end
    end else if (key.mode) begin
      for (int i = 0; i < NumDigits; i++) entry_digit_next[i] = '0;
      entry_count_next = '0;
      if (entry_target) begin
        // abort alarm entry
        next_target_alarm_next = 1'b0;
        entry_busy_next        = 1'b0;
        entry_target_next      = 1'b0;
      end else begin
        // switch over to a fresh alarm entry
        next_target_alarm_next = 1'b1;
        entry_busy_next        = 1'b1;
        entry_target_next      = 1'b1;
      end
    end else if (key.is_digit) begin
      if (entry_count == 2'd3) begin
        if (entry_target) begin
          alarm_hour_next   = set_hour[4:0];
          alarm_minute_next = set_minute[5:0];
          armed_flag_next   = 1'b1;
        end else begin
          hour_count_next   = set_hour[4:0];
          minute_count_next = set_minute[5:0];
        end
        entry_busy_next   = 1'b0;
        entry_target_next = 1'b0;
        entry_count_next  = '0;
        for (int i = 0; i < NumDigits; i++) entry_digit_next[i] = '0;
      end else begin
        entry_digit_next[entry_count] = key.digit;
        entry_count_next              = entry_count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_count        <= '0;
      minute_count      <= '0;
      second_count      <= '0;
      alarm_hour        <= '0;
      alarm_minute      <= '0;
      armed_flag        <= 1'b0;
      display_enable    <= 1'b1;
      next_target_alarm <= 1'b0;
      entry_busy        <= 1'b0;
      entry_target      <= 1'b0;
      entry_count       <= '0;
      for (int i = 0; i < NumDigits; i++) entry_digit[i] <= '0;
    end else if (accept) begin
      hour_count        <= hour_count_next;
      minute_count      <= minute_count_next;
      second_count      <= second_count_next;
      alarm_hour        <= alarm_hour_next;
      alarm_minute      <= alarm_minute_next;
      armed_flag        <= armed_flag_next;
      display_enable    <= display_enable_next;
      next_target_alarm <= next_target_alarm_next;
      entry_busy        <= entry_busy_next;
      entry_target      <= entry_target_next;
      entry_count       <= entry_count_next;
      for (int i = 0; i < NumDigits; i++) entry_digit[i] <= entry_digit_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (accept) begin
      status.valid <= 1'b1;
    end else if (status.ready) begin
      status.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status.hours          <= hour_count_next;
      status.minutes        <= minute_count_next;
      status.seconds        <= second_count_next;
      status.display_on     <= display_enable_next;
      status.alarm_sounding <= armed_flag_next && (hour_count_next == alarm_hour_next)
                               && (minute_count_next == alarm_minute_next);
      status.alarm_is_armed <= armed_flag_next;
      status.entering       <= entry_busy_next;
      status.entering_alarm <= entry_busy_next && entry_target_next;
      status.digits_entered <= entry_busy_next ? entry_count_next : 2'd0;
      // digits not yet entered are held at zero
      status.entry_value    <= entry_busy_next
                               ? {entry_digit_next[0], entry_digit_next[1],
                                  entry_digit_next[2], entry_digit_next[3]}
                               : 16'd0;
    end
  end

endmodule
